FILE: rtl/qaa_pkg.sv
`timescale 1ns / 1ps
// Shared constants and the arctangent step table for the quaternion to axis-angle block.
package qaa_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int CORDIC_STEPS   = 32;
    localparam int SQRT_IN_W      = 64;
    localparam int WQ_W           = 32;
    localparam int CORDIC_XY_W    = 36;
    localparam int ANGLE_ACC_W    = 64;

    localparam logic [ANGLE_ACC_W-1:0] PI_HALF_Q60    = 64'h1921FB54442D1846;
    localparam logic [ANGLE_ACC_W-1:0] PI_QUARTER_Q60 = 64'h0C90FDAA22168C23;

    // square, root, vector set-up, CORDIC steps, rounding
    localparam int ANGLE_LAT = 1 + SQRT_IN_W / 2 + 1 + CORDIC_STEPS + 1;

    function automatic int axis_lat(input int dw);
        return 3 * dw + 5;
    endfunction

    function automatic logic [ANGLE_ACC_W-1:0] atan_term(input int i, input int m);
        int e;
        e = i * m;
        if (e > 60) begin
            return '0;
        end
        return 64'd1 << (60 - e);
    endfunction

    // Q60 atan(2^-i), truncated series
    function automatic logic [ANGLE_ACC_W-1:0] atan_q60(input int i);
        if (i == 0) begin
            return PI_QUARTER_Q60;
        end
        return atan_term(i, 1)
            - atan_term(i, 3) / 3   + atan_term(i, 5) / 5
            - atan_term(i, 7) / 7   + atan_term(i, 9) / 9
            - atan_term(i, 11) / 11 + atan_term(i, 13) / 13
            - atan_term(i, 15) / 15 + atan_term(i, 17) / 17
            - atan_term(i, 19) / 19 + atan_term(i, 21) / 21
            - atan_term(i, 23) / 23 + atan_term(i, 25) / 25
            - atan_term(i, 27) / 27 + atan_term(i, 29) / 29
            - atan_term(i, 31) / 31 + atan_term(i, 33) / 33
            - atan_term(i, 35) / 35 + atan_term(i, 37) / 37
            - atan_term(i, 39) / 39 + atan_term(i, 41) / 41
            - atan_term(i, 43) / 43 + atan_term(i, 45) / 45
            - atan_term(i, 47) / 47 + atan_term(i, 49) / 49
            - atan_term(i, 51) / 51 + atan_term(i, 53) / 53
            - atan_term(i, 55) / 55 + atan_term(i, 57) / 57
            - atan_term(i, 59) / 59;
    endfunction

endpackage

FILE: rtl/qaa_isqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage, with a tag carried alongside.
module qaa_isqrt #(
    parameter int RAD_W = 64,
    parameter int TAG_W = 1
) (
    input  logic               aclk,
    input  logic               en,
    input  logic [RAD_W-1:0]   rad_in,
    input  logic [TAG_W-1:0]   tag_in,
    output logic [RAD_W/2-1:0] root_out,
    output logic [TAG_W-1:0]   tag_out
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic [TAG_W-1:0]  tag_reg  [ROOT_W];

    logic [REM_W-1:0]  rem_next  [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];
    logic [RAD_W-1:0]  rad_next  [ROOT_W];

    logic [REM_W-1:0]  rem_src;
    logic [ROOT_W-1:0] root_src;
    logic [RAD_W-1:0]  rad_src;
    logic [REM_W+1:0]  ext;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              ge;

    always_comb begin
        rem_src  = '0;
        root_src = '0;
        rad_src  = '0;
        ext      = '0;
        trial    = '0;
        diff     = '0;
        ge       = 1'b0;
        for (int k = 0; k < ROOT_W; k++) begin
            if (k == 0) begin
                rem_src  = '0;
                root_src = '0;
                rad_src  = rad_in;
            end else begin
                rem_src  = rem_reg[k-1];
                root_src = root_reg[k-1];
                rad_src  = rad_reg[k-1];
            end
            ext          = {rem_src, rad_src[RAD_W-1 -: 2]};
            trial        = {2'b00, root_src, 2'b01};
            diff         = ext - trial;
            ge           = (ext >= trial);
            rem_next[k]  = ge ? diff[REM_W-1:0] : ext[REM_W-1:0];
            root_next[k] = {root_src[ROOT_W-2:0], ge};
            rad_next[k]  = {rad_src[RAD_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < ROOT_W; k++) begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rad_reg[k]  <= rad_next[k];
            end
            tag_reg[0] <= tag_in;
            for (int k = 1; k < ROOT_W; k++) begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    assign root_out = root_reg[ROOT_W-1];
    assign tag_out  = tag_reg[ROOT_W-1];

endmodule

FILE: rtl/qaa_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: quotient of num * 2^DEN_W over den, one bit per stage.
module qaa_div #(
    parameter int DEN_W = 32,
    parameter int TAG_W = 1
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [DEN_W-1:0] num_in,
    input  logic [DEN_W-1:0] den_in,
    input  logic [TAG_W-1:0] tag_in,
    output logic [DEN_W:0]   quo_out,
    output logic [TAG_W-1:0] tag_out
);

    localparam int QUO_W = DEN_W + 1;

    logic [DEN_W-1:0] rem_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];
    logic [TAG_W-1:0] tag_reg [QUO_W];

    logic [DEN_W-1:0] rem_next [QUO_W];
    logic [QUO_W-1:0] quo_next [QUO_W];

    logic [DEN_W:0]   work;
    logic [DEN_W:0]   diff;
    logic [DEN_W-1:0] den_src;
    logic [QUO_W-1:0] quo_src;
    logic             ge;

    always_comb begin
        work    = '0;
        diff    = '0;
        den_src = '0;
        quo_src = '0;
        ge      = 1'b0;
        for (int k = 0; k < QUO_W; k++) begin
            if (k == 0) begin
                work    = {1'b0, num_in};
                den_src = den_in;
                quo_src = '0;
            end else begin
                work    = {rem_reg[k-1], 1'b0};
                den_src = den_reg[k-1];
                quo_src = quo_reg[k-1];
            end
            ge          = (work >= {1'b0, den_src});
            diff        = work - {1'b0, den_src};
            rem_next[k] = ge ? diff[DEN_W-1:0] : work[DEN_W-1:0];
            quo_next[k] = {quo_src[QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < QUO_W; k++) begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
            end
            den_reg[0] <= den_in;
            tag_reg[0] <= tag_in;
            for (int k = 1; k < QUO_W; k++) begin
                den_reg[k] <= den_reg[k-1];
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    assign quo_out = quo_reg[QUO_W-1];
    assign tag_out = tag_reg[QUO_W-1];

endmodule

FILE: rtl/qaa_angle.sv
`timescale 1ns / 1ps
// Angle path: sine of the half angle by square root, CORDIC vectoring, rounding to Q3.
module qaa_angle #(
    parameter int DATA_WIDTH = qaa_pkg::DATA_WIDTH_DEF,
    parameter int PAD        = 0
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic signed [DATA_WIDTH-1:0] quat_w,
    output logic        [DATA_WIDTH-1:0] rot_angle
);

    import qaa_pkg::*;

    localparam int D     = DATA_WIDTH;
    localparam int XY_W  = CORDIC_XY_W;
    localparam int Z_W   = ANGLE_ACC_W;
    localparam int SH    = 62 - D;
    localparam int ROOT_W = SQRT_IN_W / 2;

    logic        [D-1:0]         wm;
    logic        [2*D-1:0]       sq_reg;
    logic signed [WQ_W-1:0]      wq_reg;
    logic        [SQRT_IN_W-1:0] rad;
    logic        [ROOT_W-1:0]    s_root;
    logic        [WQ_W-1:0]      wq_tag;

    logic signed [XY_W-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  z_reg [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] x_next [CORDIC_STEPS];
    logic signed [XY_W-1:0] y_next [CORDIC_STEPS];
    logic signed [Z_W-1:0]  z_next [CORDIC_STEPS];
    logic        [Z_W-1:0]  atan_tbl [CORDIC_STEPS];

    logic signed [XY_W-1:0] x0_next;
    logic signed [XY_W-1:0] y0_next;
    logic signed [Z_W-1:0]  z0_next;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    logic [Z_W-1:0] h_pos;
    logic [Z_W-1:0] h_sum;
    logic [Z_W-1:0] h_shift;
    logic [D-1:0]   ang_next;
    logic [D-1:0]   ang_reg;

    assign wm = quat_w[D-1] ? (~quat_w + 1'b1) : quat_w;

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg <= {{D{1'b0}}, wm} * {{D{1'b0}}, wm};
            wq_reg <= WQ_W'(quat_w) <<< (WQ_W - D);
        end
    end

    assign rad = (64'd1 << 62) - (SQRT_IN_W'(sq_reg) << (SQRT_IN_W - 2 * D));

    qaa_isqrt #(
        .RAD_W (SQRT_IN_W),
        .TAG_W (WQ_W)
    ) u_sqrt (
        .aclk     (aclk),
        .en       (en),
        .rad_in   (rad),
        .tag_in   (wq_reg),
        .root_out (s_root),
        .tag_out  (wq_tag)
    );

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_tbl
        localparam logic [Z_W-1:0] STEP_ANGLE = atan_q60(g);
        assign atan_tbl[g] = STEP_ANGLE;
    end

    // negative w: pre-rotate by -pi/2
    always_comb begin
        if (!wq_tag[WQ_W-1]) begin
            x0_next = XY_W'($signed(wq_tag));
            y0_next = $signed(XY_W'(s_root));
            z0_next = '0;
        end else begin
            x0_next = $signed(XY_W'(s_root));
            y0_next = -XY_W'($signed(wq_tag));
            z0_next = $signed(PI_HALF_Q60);
        end
    end

    always_comb begin
        dx = '0;
        dy = '0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y_reg[i] >>> i;
            dy = x_reg[i] >>> i;
            if (!y_reg[i][XY_W-1] && (y_reg[i] != '0)) begin
                x_next[i] = x_reg[i] + dx;
                y_next[i] = y_reg[i] - dy;
                z_next[i] = z_reg[i] + $signed(atan_tbl[i]);
            end else begin
                x_next[i] = x_reg[i] - dx;
                y_next[i] = y_reg[i] + dy;
                z_next[i] = z_reg[i] - $signed(atan_tbl[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= x0_next;
            y_reg[0] <= y0_next;
            z_reg[0] <= z0_next;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                x_reg[i+1] <= x_next[i];
                y_reg[i+1] <= y_next[i];
                z_reg[i+1] <= z_next[i];
            end
        end
    end

    assign h_pos   = z_reg[CORDIC_STEPS][Z_W-1] ? '0 : z_reg[CORDIC_STEPS];
    assign h_sum   = h_pos + (64'd1 << (SH - 1));
    assign h_shift = h_sum >> SH;
    assign ang_next = (h_shift > Z_W'({D{1'b1}})) ? {D{1'b1}} : h_shift[D-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            ang_reg <= ang_next;
        end
    end

    if (PAD > 0) begin : g_pad
        logic [D-1:0] pad_reg [PAD];
        always_ff @(posedge aclk) begin
            if (en) begin
                pad_reg[0] <= ang_reg;
                for (int k = 1; k < PAD; k++) begin
                    pad_reg[k] <= pad_reg[k-1];
                end
            end
        end
        assign rot_angle = pad_reg[PAD-1];
    end else begin : g_nopad
        assign rot_angle = ang_reg;
    end

endmodule

FILE: rtl/qaa_axis.sv
`timescale 1ns / 1ps
// Axis path: squared norm, per-component division and root, rounding and saturation.
module qaa_axis #(
    parameter int DATA_WIDTH = qaa_pkg::DATA_WIDTH_DEF,
    parameter int PAD        = 0
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic signed [DATA_WIDTH-1:0] quat_x,
    input  logic signed [DATA_WIDTH-1:0] quat_y,
    input  logic signed [DATA_WIDTH-1:0] quat_z,
    output logic signed [DATA_WIDTH-1:0] axis_x,
    output logic signed [DATA_WIDTH-1:0] axis_y,
    output logic signed [DATA_WIDTH-1:0] axis_z,
    output logic                         axis_zero
);

    localparam int D      = DATA_WIDTH;
    localparam int SQ_W   = 2 * D;
    localparam int ROOT_W = D + 1;
    localparam int FRAC_W = D - 1;
    localparam int RES_W  = 3 * D + 1;
    localparam logic [ROOT_W-1:0] Q_MAX = ROOT_W'((64'd1 << FRAC_W) - 64'd1);

    logic [D-1:0]    comp [3];
    logic [D-1:0]    mag  [3];
    logic [SQ_W-1:0] sq_reg  [3];
    logic [2:0]      sgn1_reg;
    logic [SQ_W-1:0] sq2_reg [3];
    logic [2:0]      sgn2_reg;
    logic [SQ_W-1:0] n_reg;
    logic [SQ_W-1:0] n_next;
    logic            zero2_reg;

    logic [SQ_W:0]     quo  [3];
    logic [1:0]        dtag [3];
    logic [ROOT_W-1:0] root [3];
    logic [1:0]        rtag [3];

    logic [ROOT_W:0]   rsum [3];
    logic [ROOT_W-1:0] qr   [3];
    logic [D-1:0]      qd   [3];
    logic [D-1:0]      val  [3];
    logic [RES_W-1:0]  res_next;
    logic [RES_W-1:0]  res_reg;
    logic [RES_W-1:0]  res_out;

    assign comp[0] = quat_x;
    assign comp[1] = quat_y;
    assign comp[2] = quat_z;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            mag[c] = comp[c][D-1] ? (~comp[c] + 1'b1) : comp[c];
        end
    end

    assign n_next = sq_reg[0] + sq_reg[1] + sq_reg[2];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                sq_reg[c]   <= {{D{1'b0}}, mag[c]} * {{D{1'b0}}, mag[c]};
                sgn1_reg[c] <= comp[c][D-1];
                sq2_reg[c]  <= sq_reg[c];
            end
            sgn2_reg  <= sgn1_reg;
            n_reg     <= n_next;
            zero2_reg <= (n_next == '0);
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_comp
        qaa_div #(
            .DEN_W (SQ_W),
            .TAG_W (2)
        ) u_div (
            .aclk    (aclk),
            .en      (en),
            .num_in  (sq2_reg[c]),
            .den_in  (n_reg),
            .tag_in  ({zero2_reg, sgn2_reg[c]}),
            .quo_out (quo[c]),
            .tag_out (dtag[c])
        );

        qaa_isqrt #(
            .RAD_W (SQ_W + 2),
            .TAG_W (2)
        ) u_sqrt (
            .aclk     (aclk),
            .en       (en),
            .rad_in   ({1'b0, quo[c]}),
            .tag_in   (dtag[c]),
            .root_out (root[c]),
            .tag_out  (rtag[c])
        );
    end

    // nearest, ties up; capped below +1.0
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            rsum[c] = {1'b0, root[c]} + 1'b1;
            qr[c]   = rsum[c][ROOT_W:1];
            qd[c]   = (qr[c] > Q_MAX) ? Q_MAX[D-1:0] : qr[c][D-1:0];
            if (rtag[c][1]) begin
                val[c] = '0;
            end else if (rtag[c][0]) begin
                val[c] = ~qd[c] + 1'b1;
            end else begin
                val[c] = qd[c];
            end
        end
        res_next = {rtag[0][1], val[2], val[1], val[0]};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    if (PAD > 0) begin : g_pad
        logic [RES_W-1:0] pad_reg [PAD];
        always_ff @(posedge aclk) begin
            if (en) begin
                pad_reg[0] <= res_reg;
                for (int k = 1; k < PAD; k++) begin
                    pad_reg[k] <= pad_reg[k-1];
                end
            end
        end
        assign res_out = pad_reg[PAD-1];
    end else begin : g_nopad
        assign res_out = res_reg;
    end

    assign axis_x    = res_out[D-1:0];
    assign axis_y    = res_out[2*D-1:D];
    assign axis_z    = res_out[3*D-1:2*D];
    assign axis_zero = res_out[3*D];

endmodule

FILE: rtl/quaternion_to_axis_angle.sv
`timescale 1ns / 1ps
// Top level: quaternion to axis-angle converter, handshake and output register.
//
//  channel  dir  handshake          payload
//  s_       in   s_valid/s_ready    s_quat_w, s_quat_x, s_quat_y, s_quat_z
//  m_       out  m_valid/m_ready    m_rot_angle, m_axis_x/y/z, m_axis_zero
//
// One beat per cycle in and out while the pipeline is not held. Depth is set by the
// longer of the angle path (32-step root, 32-step CORDIC) and the axis path.
// aresetn clears only the valid bits; data registers are not reset.
// Pipeline holds only when its last stage and the output register both hold a beat
// and m_ready is low; bubbles are squeezed out meanwhile.
module quaternion_to_axis_angle #(
    parameter int DATA_WIDTH = qaa_pkg::DATA_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [DATA_WIDTH-1:0] s_quat_w,
    input  logic signed [DATA_WIDTH-1:0] s_quat_x,
    input  logic signed [DATA_WIDTH-1:0] s_quat_y,
    input  logic signed [DATA_WIDTH-1:0] s_quat_z,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic        [DATA_WIDTH-1:0] m_rot_angle,
    output logic signed [DATA_WIDTH-1:0] m_axis_x,
    output logic signed [DATA_WIDTH-1:0] m_axis_y,
    output logic signed [DATA_WIDTH-1:0] m_axis_z,
    output logic                         m_axis_zero
);

    import qaa_pkg::*;

    localparam int AXIS_LAT = axis_lat(DATA_WIDTH);
    localparam int LAT      = (ANGLE_LAT > AXIS_LAT) ? ANGLE_LAT : AXIS_LAT;

    logic [LAT:1] vld_reg;
    logic         m_valid_reg;
    logic         out_load;
    logic         en;

    logic        [DATA_WIDTH-1:0] ang_pipe;
    logic signed [DATA_WIDTH-1:0] ax_pipe;
    logic signed [DATA_WIDTH-1:0] ay_pipe;
    logic signed [DATA_WIDTH-1:0] az_pipe;
    logic                         zero_pipe;

    logic        [DATA_WIDTH-1:0] rot_angle_reg;
    logic signed [DATA_WIDTH-1:0] axis_x_reg;
    logic signed [DATA_WIDTH-1:0] axis_y_reg;
    logic signed [DATA_WIDTH-1:0] axis_z_reg;
    logic                         axis_zero_reg;

    assign out_load = !m_valid_reg || m_ready;
    assign en       = out_load || !vld_reg[LAT];
    assign s_ready  = en;

    qaa_angle #(
        .DATA_WIDTH (DATA_WIDTH),
        .PAD        (LAT - ANGLE_LAT)
    ) u_angle (
        .aclk      (aclk),
        .en        (en),
        .quat_w    (s_quat_w),
        .rot_angle (ang_pipe)
    );

    qaa_axis #(
        .DATA_WIDTH (DATA_WIDTH),
        .PAD        (LAT - AXIS_LAT)
    ) u_axis (
        .aclk      (aclk),
        .en        (en),
        .quat_x    (s_quat_x),
        .quat_y    (s_quat_y),
        .quat_z    (s_quat_z),
        .axis_x    (ax_pipe),
        .axis_y    (ay_pipe),
        .axis_z    (az_pipe),
        .axis_zero (zero_pipe)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en) begin
                vld_reg[1] <= s_valid;
                for (int k = 2; k <= LAT; k++) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
            if (out_load) begin
                m_valid_reg <= vld_reg[LAT];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            rot_angle_reg <= ang_pipe;
            axis_x_reg    <= ax_pipe;
            axis_y_reg    <= ay_pipe;
            axis_z_reg    <= az_pipe;
            axis_zero_reg <= zero_pipe;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_rot_angle = rot_angle_reg;
    assign m_axis_x    = axis_x_reg;
    assign m_axis_y    = axis_y_reg;
    assign m_axis_z    = axis_z_reg;
    assign m_axis_zero = axis_zero_reg;

endmodule
